/* sv/bep_pkg.sv */
// Shared widths, codes and beat types for the bounded elite pool.
`timescale 1ns / 1ps
`default_nettype none
package bep_pkg;

	// Built depth of the pool and derived widths
	localparam int POOL_DEPTH = 16;
	localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int HALF_W     = CNT_W - 1;

	// Fixed field widths
	localparam int ACTION_W = 2;
	localparam int SCORE_W  = 32;
	localparam int HANDLE_W = 32;
	localparam int SEED_W   = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int FILL_W   = 5;
	localparam int CAP_W    = 5;
	localparam int ENTRY_W  = SCORE_W + HANDLE_W;

	// Width wide enough to compare capacity against the fill count
	localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int MOD_CNT_W = $clog2(SEED_W);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

	typedef logic signed [SCORE_W-1:0] score_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		score_t              new_score;
		logic [HANDLE_W-1:0] payload_handle;
		logic [SEED_W-1:0]   seed;
	} cmd_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] out_payload;
		score_t              out_score;
		score_t              worst_score;
		logic [FILL_W-1:0]   fill_count;
	} rsp_beat_t;

	// Remainder unit request and response
	typedef struct packed {
		logic              start;
		logic [SEED_W-1:0] dividend;
		logic [HALF_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [HALF_W-1:0] rem;
	} mod_rsp_t;

endpackage
`default_nettype wire

/* sv/bep_ifs.sv */
// Valid/ready channel interfaces for command and response beats.
`timescale 1ns / 1ps
`default_nettype none
interface bep_cmd_if;
	import bep_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	score_t              new_score;
	logic [HANDLE_W-1:0] payload_handle;
	logic [SEED_W-1:0]   seed;

	modport source (output valid, action, new_score, payload_handle, seed, input ready);
	modport sink   (input valid, action, new_score, payload_handle, seed, output ready);
endinterface

interface bep_rsp_if;
	import bep_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [HANDLE_W-1:0] out_payload;
	score_t              out_score;
	score_t              worst_score;
	logic [FILL_W-1:0]   fill_count;

	modport source (output valid, status, slot, out_payload, out_score, worst_score,
		fill_count, input ready);
	modport sink   (input valid, status, slot, out_payload, out_score, worst_score,
		fill_count, output ready);
endinterface
`default_nettype wire

/* sv/bep_ram.sv */
// Simple dual-port synchronous RAM, registered read.
`timescale 1ns / 1ps
`default_nettype none
module bep_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  wire logic                                        clk,
	input  wire logic                                        wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

/* sv/bep_mod.sv */
// Bit-serial remainder unit: seed mod half, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bep_mod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bep_pkg::mod_req_t req,
	output bep_pkg::mod_rsp_t      rsp
);
	import bep_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SEED_W-1:0]    num_q;
	logic [HALF_W-1:0]    den_q;
	logic [HALF_W-1:0]    rem_q;
	logic [HALF_W:0]      r_sh;
	logic [HALF_W:0]      r_diff;
	logic [HALF_W-1:0]    r_new;

	// restoring step: remainder stays below the divisor, so one subtract suffices
	always_comb begin
		r_sh   = {rem_q, num_q[SEED_W-1]};
		r_diff = r_sh - {1'b0, den_q};
		r_new  = (r_sh >= {1'b0, den_q}) ? r_diff[HALF_W-1:0] : r_sh[HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(SEED_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SEED_W-2:0], 1'b0};
			rem_q <= r_new;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

/* sv/bep_ctrl.sv */
// Pool sequencer: min scans, rank scans and read-modify-write of the entry RAM.
`timescale 1ns / 1ps
`default_nettype none
module bep_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [bep_pkg::CAP_W-1:0]           cap,
	input  wire logic                                cmd_valid,
	input  wire bep_pkg::cmd_beat_t                  cmd,
	output logic                                     cmd_ready,
	input  wire logic                                res_free,
	output logic                                     res_load,
	output bep_pkg::rsp_beat_t                       res,
	output logic                                     wr_en,
	output logic [bep_pkg::IDX_W-1:0]                wr_addr,
	output logic [bep_pkg::ENTRY_W-1:0]              wr_data,
	output logic                                     rd_en,
	output logic [bep_pkg::IDX_W-1:0]                rd_addr,
	input  wire logic [bep_pkg::ENTRY_W-1:0]         rd_data,
	output bep_pkg::mod_req_t                        mod_req,
	input  wire bep_pkg::mod_rsp_t                   mod_rsp
);
	import bep_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_MINSCAN   = 8'b0000_0010,
		S_DECIDE    = 8'b0000_0100,
		S_MOD       = 8'b0000_1000,
		S_RANK_LD   = 8'b0001_0000,
		S_RANK_HOLD = 8'b0010_0000,
		S_RANK_SCAN = 8'b0100_0000,
		S_RESULT    = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	score_t            score_q;
	logic [HANDLE_W-1:0] handle_q;
	logic              final_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]  slot_q;
	logic [HANDLE_W-1:0] opay_q;
	score_t            oscore_q;
	score_t            worst_q;
	score_t            min_q;
	logic [IDX_W-1:0]  min_slot_q;
	logic [HALF_W-1:0] pick_q;
	logic [IDX_W-1:0]  i_q;
	score_t            si_q;
	logic [HANDLE_W-1:0] pi_q;
	logic [CNT_W-1:0]  rank_q;

	logic              accept;
	logic              is_add;
	logic              is_sel;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  eff_cap;
	logic              full;
	logic [CNT_W-1:0]  cnt_m1;
	logic              issue_en;
	logic              scan_last;
	score_t            rd_score;
	logic [HANDLE_W-1:0] rd_pay;
	logic              take_min;
	score_t            min_nxt;
	logic [IDX_W-1:0]  min_slot_nxt;
	logic              hit;
	logic [CNT_W-1:0]  rank_nxt;
	logic              found;
	logic              replace;
	logic [HALF_W-1:0] half_raw;

	always_comb begin
		case (cmd.action)
			ACT_ADD: begin
				is_add = 1'b1;
				is_sel = 1'b0;
			end
			ACT_SELECT: begin
				is_add = 1'b0;
				is_sel = 1'b1;
			end
			ACT_QUERY: begin
				is_add = 1'b0;
				is_sel = 1'b0;
			end
			default: begin
				is_add = 1'b0;
				is_sel = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == S_IDLE);
		accept    = cmd_valid && cmd_ready;

		// capacity 0 acts as 1, above the built depth as the depth
		cap_ext = CMP_W'(cap);
		if (cap == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(POOL_DEPTH)) begin
			eff_cap = CMP_W'(POOL_DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
		full = CMP_W'(count_q) >= eff_cap;

		cnt_m1    = count_q - 1'b1;
		issue_en  = ((state_q == S_MINSCAN) || (state_q == S_RANK_SCAN)) && (issue_q < count_q);
		scan_last = rd_vld_s1 && (rd_idx_s1 == cnt_m1[IDX_W-1:0]);

		rd_score = score_t'(rd_data[ENTRY_W-1:HANDLE_W]);
		rd_pay   = rd_data[HANDLE_W-1:0];

		// running minimum, lowest slot wins ties
		take_min     = (rd_idx_s1 == '0) || (rd_score < min_q);
		min_nxt      = take_min ? rd_score : min_q;
		min_slot_nxt = take_min ? rd_idx_s1 : min_slot_q;

		// entry j outranks entry i
		hit      = (rd_score > si_q) || ((rd_score == si_q) && (rd_idx_s1 < i_q));
		rank_nxt = rank_q + CNT_W'(hit);
		found    = (rank_nxt == CNT_W'(pick_q));

		replace = (state_q == S_DECIDE) && (score_q > min_q);

		half_raw = count_q[CNT_W-1:1];
	end

	// RAM ports
	always_comb begin
		if (state_q == S_DECIDE) begin
			wr_en   = replace;
			wr_addr = min_slot_q;
			wr_data = {score_q, handle_q};
		end else begin
			wr_en   = accept && is_add && !full;
			wr_addr = count_q[IDX_W-1:0];
			wr_data = {cmd.new_score, cmd.payload_handle};
		end
		rd_en   = issue_en || (state_q == S_RANK_LD);
		rd_addr = (state_q == S_RANK_LD) ? i_q : issue_q[IDX_W-1:0];
	end

	always_comb begin
		mod_req.start    = accept && is_sel && (count_q != '0);
		mod_req.dividend = cmd.seed;
		mod_req.divisor  = (half_raw == '0) ? HALF_W'(1) : half_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			if (scan_last || ((state_q != S_MINSCAN) && (state_q != S_RANK_SCAN))) begin
				issue_q <= '0;
			end else if (issue_en) begin
				issue_q <= issue_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_add) begin
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= S_MINSCAN;
						end else if (count_q == '0) begin
							state_q <= S_RESULT;
						end else if (is_sel) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_MINSCAN;
						end
					end
				end
				S_MINSCAN: begin
					if (scan_last) begin
						state_q <= final_q ? S_RESULT : S_DECIDE;
					end
				end
				S_DECIDE: state_q <= S_MINSCAN;
				S_MOD: begin
					if (mod_rsp.done) begin
						state_q <= S_RANK_LD;
					end
				end
				S_RANK_LD:   state_q <= S_RANK_HOLD;
				S_RANK_HOLD: state_q <= S_RANK_SCAN;
				S_RANK_SCAN: begin
					if (scan_last) begin
						state_q <= found ? S_MINSCAN : S_RANK_LD;
					end
				end
				S_RESULT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					score_q  <= cmd.new_score;
					handle_q <= cmd.payload_handle;
					final_q  <= !(is_add && full);
					status_q <= (is_sel && (count_q == '0)) ? ST_EMPTY : ST_OK;
					slot_q   <= (is_add && !full) ? count_q[IDX_W-1:0] : '0;
					opay_q   <= '0;
					oscore_q <= '0;
					worst_q  <= '0;
				end
			end
			S_MINSCAN: begin
				if (rd_vld_s1) begin
					min_q      <= min_nxt;
					min_slot_q <= min_slot_nxt;
				end
				if (scan_last && final_q) begin
					worst_q <= min_nxt;
				end
			end
			S_DECIDE: begin
				final_q <= 1'b1;
				if (replace) begin
					slot_q <= min_slot_q;
				end else begin
					status_q <= ST_REJECT;
				end
			end
			S_MOD: begin
				pick_q <= mod_rsp.rem;
				i_q    <= '0;
			end
			S_RANK_HOLD: begin
				si_q   <= rd_score;
				pi_q   <= rd_pay;
				rank_q <= '0;
			end
			S_RANK_SCAN: begin
				if (rd_vld_s1) begin
					rank_q <= rank_nxt;
				end
				if (scan_last) begin
					if (found) begin
						slot_q   <= i_q;
						opay_q   <= pi_q;
						oscore_q <= si_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_load        = (state_q == S_RESULT) && res_free;
		res.status      = status_q;
		res.slot        = SLOT_W'(slot_q);
		res.out_payload = opay_q;
		res.out_score   = oscore_q;
		res.worst_score = worst_q;
		res.fill_count  = FILL_W'(count_q);
	end
endmodule
`default_nettype wire

/* sv/bounded_elite_pool.sv */
// Top level of the bounded elite pool: capacity register, output register, core.
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+----------------------------------------------
//  cmd     | in  | valid/ready        | action, new_score, payload_handle, seed
//  rsp     | out | valid/ready        | status, slot, out_payload, out_score,
//          |     |                    | worst_score, fill_count
//  cfg     | in  | cfg_wr_en, no wait | cfg_wr_data = capacity
//
// One command in flight. Steps per beat, from an accept to the next accept when the
// output register is free:
//   add into a free slot : write, then one worst-score pass over the RAM
//   add into a full pool : worst-slot pass, write-back, worst-score pass
//   select               : bit-serial remainder, then one rank pass per candidate,
//                          from slot 0 up to the one chosen, then a worst-score pass
//   query                : one worst-score pass; on an empty pool, no pass at all
// Every pass streams the single read port of the entry RAM, one entry a cycle.
// Reset clears the fill count, not the entries; no clearing pass, entries at or above the count
// are never read. A finished beat waits in the output register, so the next command
// is taken while the response stage is stalled.
`timescale 1ns / 1ps
`default_nettype none
module bounded_elite_pool (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bep_pkg::CAP_W-1:0]  cfg_wr_data,
	bep_cmd_if.sink                         cmd,
	bep_rsp_if.source                       rsp
);
	import bep_pkg::*;

	logic [CAP_W-1:0]   cap_q;
	logic               rsp_vld_q;
	rsp_beat_t          rsp_q;

	cmd_beat_t          cmd_beat;
	logic               cmd_ready;
	logic               res_free;
	logic               res_load;
	rsp_beat_t          res;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	mod_req_t           mod_req;
	mod_rsp_t           mod_rsp;

	// Capacity register, to be written only while the pool is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_comb begin
		cmd_beat.action         = cmd.action;
		cmd_beat.new_score      = cmd.new_score;
		cmd_beat.payload_handle = cmd.payload_handle;
		cmd_beat.seed           = cmd.seed;
		cmd.ready               = cmd_ready;
	end

	// Output register: takes a new beat when empty or being drained this cycle.
	assign res_free = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_free) begin
			rsp_vld_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	always_comb begin
		rsp.valid       = rsp_vld_q;
		rsp.status      = rsp_q.status;
		rsp.slot        = rsp_q.slot;
		rsp.out_payload = rsp_q.out_payload;
		rsp.out_score   = rsp_q.out_score;
		rsp.worst_score = rsp_q.worst_score;
		rsp.fill_count  = rsp_q.fill_count;
	end

	// Entry RAM: {score, payload handle} per slot.
	bep_ram #(
		.DEPTH (POOL_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// seed mod max(1, count/2) for select
	bep_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	bep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.cmd_valid (cmd.valid),
		.cmd       (cmd_beat),
		.cmd_ready (cmd_ready),
		.res_free  (res_free),
		.res_load  (res_load),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.mod_req   (mod_req),
		.mod_rsp   (mod_rsp)
	);
endmodule
`default_nettype wire

/* sv/bep_chk.sv */
// Port-level checker for the bounded elite pool, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bep_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [bep_pkg::STATUS_W-1:0]  rsp_status,
	input wire logic [bep_pkg::SLOT_W-1:0]    rsp_slot,
	input wire logic [bep_pkg::HANDLE_W-1:0]  rsp_out_payload,
	input wire logic [bep_pkg::SCORE_W-1:0]   rsp_out_score,
	input wire logic [bep_pkg::SCORE_W-1:0]   rsp_worst_score,
	input wire logic [bep_pkg::FILL_W-1:0]    rsp_fill_count
);
	import bep_pkg::*;

	// a stalled response beat stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat withdrawn while stalled");

	// an empty status comes with an empty pool, zero worst score and slot 0
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY) |->
			(rsp_fill_count == '0) && (rsp_worst_score == '0) && (rsp_slot == '0))
		else $error("empty status with stored entries");

	// a rejected add carries no entry and needs a populated pool
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_REJECT) |->
			(rsp_slot == '0) && (rsp_out_payload == '0) && (rsp_out_score == '0) &&
			(rsp_fill_count != '0))
		else $error("reject beat carries entry data");

	// fill count never exceeds the built depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp_fill_count} <= (FILL_W + 1)'(POOL_DEPTH)))
		else $error("fill count beyond pool depth");
endmodule

bind bounded_elite_pool bep_chk u_bep_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot        (rsp.slot),
	.rsp_out_payload (rsp.out_payload),
	.rsp_out_score   (rsp.out_score),
	.rsp_worst_score (rsp.worst_score),
	.rsp_fill_count  (rsp.fill_count)
);
`default_nettype wire

/* test/elite_pool_checker.sv */
// Checker for the bounded elite pool: watches both channels, predicts and compares beats.
`timescale 1ns / 1ps
module elite_pool_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [bep_pkg::CAP_W-1:0] cfg_wr_data,
	bep_cmd_if                             cmd,
	bep_rsp_if                             rsp,
	output int                             failures,
	output int                             outstanding
);
	import bep_pkg::*;

	// Mirror of the pool contents
	score_t              stored_score [POOL_DEPTH];
	logic [HANDLE_W-1:0] stored_handle [POOL_DEPTH];
	int unsigned         fill_level = 0;
	logic [CAP_W-1:0]    capacity_reg = CAP_RESET;
	rsp_beat_t           due_results [$];

	initial begin
		failures = 0;
		outstanding = 0;
	end

	// Lowest score, lowest slot on ties
	function automatic int unsigned lowest_slot();
		int unsigned w;
		w = 0;
		for (int unsigned i = 1; i < fill_level; i++)
			if (stored_score[i] < stored_score[w])
				w = i;
		return w;
	endfunction

	function automatic rsp_beat_t pool_step(logic [ACTION_W-1:0] act, score_t sc,
		logic [HANDLE_W-1:0] hd, logic [SEED_W-1:0] sd);
		rsp_beat_t   r;
		int unsigned room, w, half, pick, rank;
		r = '0;
		r.status = ST_OK;
		// out-of-range capacity clamps to 1..depth
		room = (capacity_reg == 0) ? 1 :
			(capacity_reg > POOL_DEPTH) ? POOL_DEPTH : capacity_reg;
		if (act == ACT_ADD) begin
			if (fill_level < room) begin
				r.slot = SLOT_W'(fill_level);
				stored_score[fill_level] = sc;
				stored_handle[fill_level] = hd;
				fill_level++;
			end else begin
				// full, or capacity dropped below the fill
				w = lowest_slot();
				if (sc > stored_score[w]) begin
					stored_score[w] = sc;
					stored_handle[w] = hd;
					r.slot = SLOT_W'(w);
				end else begin
					r.status = ST_REJECT;
				end
			end
		end else if (act == ACT_SELECT) begin
			if (fill_level == 0) begin
				r.status = ST_EMPTY;
			end else begin
				half = (fill_level / 2 < 1) ? 1 : fill_level / 2;
				pick = sd % half;
				for (int unsigned i = 0; i < fill_level; i++) begin
					rank = 0;
					for (int unsigned j = 0; j < fill_level; j++)
						if (stored_score[j] > stored_score[i] ||
							(stored_score[j] == stored_score[i] && j < i))
							rank++;
					if (rank == pick) begin
						r.slot = SLOT_W'(i);
						r.out_payload = stored_handle[i];
						r.out_score = stored_score[i];
						break;
					end
				end
			end
		end
		// query and the spare code leave the pool alone
		if (fill_level > 0)
			r.worst_score = stored_score[lowest_slot()];
		r.fill_count = FILL_W'(fill_level);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_beat_t seen, want;
		if (!arst_n) begin
			fill_level = 0;
			capacity_reg = CAP_RESET;
			due_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_wr_en)
				capacity_reg = cfg_wr_data;
			// response side first: a beat leaving now belongs to an earlier command
			if (rsp.valid && rsp.ready) begin
				seen.status = rsp.status;
				seen.slot = rsp.slot;
				seen.out_payload = rsp.out_payload;
				seen.out_score = rsp.out_score;
				seen.worst_score = rsp.worst_score;
				seen.fill_count = rsp.fill_count;
				if (due_results.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected response beat %h", $realtime, seen);
					failures++;
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						if (failures < 10)
							$display({"%0t: mismatch want st=%0d slot=%0d pay=%h sc=%h ",
								"worst=%h fill=%0d got st=%0d slot=%0d pay=%h sc=%h ",
								"worst=%h fill=%0d"}, $realtime,
								want.status, want.slot, want.out_payload, want.out_score,
								want.worst_score, want.fill_count,
								seen.status, seen.slot, seen.out_payload, seen.out_score,
								seen.worst_score, seen.fill_count);
						failures++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				due_results.insert(due_results.size(), pool_step(cmd.action, cmd.new_score,
					cmd.payload_handle, cmd.seed));
			outstanding = due_results.size();
		end
	end
endmodule

/* test/testbench.sv */
// Top of the bounded elite pool testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import bep_pkg::*;

	// spare action code, treated by the block as a query
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	// receiver hold-off, long enough to park a beat and stall the command side
	localparam int HOLD_CYCLES = 1500;
	// margin after the last beat
	localparam int TAIL_CYCLES = 500;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_BEATS = 104;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;

	bep_cmd_if cmd_ch ();
	bep_rsp_if rsp_ch ();

	int fail_count;
	int results_due;
	int cycle_count = 0;

	// idle percentages, set by the stimulus, read by both sides
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// bumped by the stimulus to ask the receiver for one long hold-off
	int hold_requests = 0;

	// rising score stream so that a full pool keeps seeing replacements
	int ramp_score = 32'sh7F00_0000;

	bounded_elite_pool dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch)
	);

	elite_pool_checker watcher (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.failures    (fail_count),
		.outstanding (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Response side: random back-pressure, plus a long hold-off on request.
	// The hold-off is counted here so it runs while the stimulus keeps offering beats.
	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one command beat and wait for it to be taken. Valid stays high on exit,
	// so back-to-back beats never drop it; idle gaps are inserted up front.
	task automatic offer_beat(logic [ACTION_W-1:0] act, score_t sc,
		logic [HANDLE_W-1:0] hd, logic [SEED_W-1:0] sd);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.new_score <= sc;
		cmd_ch.payload_handle <= hd;
		cmd_ch.seed <= sd;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering and wait for every predicted beat to come back. The first edge
	// lets the checker log the final accepted command before the count is read.
	task automatic drain_pool();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	// Only called with the block drained
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random beat: adds dominate, scores mix full-range noise, a small tie-prone set
	// and the rising stream; seeds are either full-range or small.
	task automatic offer_random_beat();
		logic [ACTION_W-1:0] act;
		score_t              sc;
		int unsigned         pick;
		pick = $urandom_range(99);
		act = (pick < 55) ? ACT_ADD : (pick < 85) ? ACT_SELECT :
			(pick < 95) ? ACT_QUERY : ACT_SPARE;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5: sc = score_t'($urandom);
			6, 7, 8, 9: sc = score_t'((int'($urandom_range(8)) - 4) * 65536);
			default: begin
				// occasional repeat of the last value gives ties inside a full pool
				if ($urandom_range(3) != 0 && ramp_score < 32'sh7FF0_0000)
					ramp_score += int'($urandom_range(24576));
				sc = score_t'(ramp_score);
			end
		endcase
		offer_beat(act, sc, $urandom,
			($urandom_range(1) != 0) ? $urandom : $urandom_range(20));
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0] phase_caps [10];
		phase_caps = '{5'd8, 5'd0, 5'd12, 5'd3, 5'd16, 5'd31, 5'd1, 5'd16, 5'd5, 5'd31};

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_QUERY;
		cmd_ch.new_score <= '0;
		cmd_ch.payload_handle <= '0;
		cmd_ch.seed <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pool first, capacity at its reset value
		offer_beat(ACT_SELECT, '0, '0, 32'hFFFF_FFFF);
		offer_beat(ACT_QUERY, '0, '0, '0);
		offer_beat(ACT_SPARE, '0, '0, '0);
		// score extremes, zero, minus one and a tied pair
		offer_beat(ACT_ADD, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, '0);
		offer_beat(ACT_ADD, 32'sh8000_0000, 32'h0000_0000, '0);
		offer_beat(ACT_ADD, 32'sh0000_0000, 32'h1234_5678, '0);
		offer_beat(ACT_ADD, 32'shFFFF_FFFF, 32'hA5A5_A5A5, '0);
		offer_beat(ACT_ADD, 32'sh0001_0000, 32'h0000_0001, '0);
		offer_beat(ACT_ADD, 32'sh0001_0000, 32'h0000_0002, '0);
		offer_beat(ACT_SELECT, '0, '0, 32'h0000_0000);
		offer_beat(ACT_SELECT, '0, '0, 32'hFFFF_FFFF);
		offer_beat(ACT_SELECT, '0, '0, 32'h0000_0002);
		offer_beat(ACT_QUERY, '0, '0, '0);
		offer_beat(ACT_SPARE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_pool();

		// capacity below the fill: pool counts as full
		write_capacity(5'd2);
		offer_beat(ACT_ADD, 32'sh8000_0000, 32'h0BAD_0BAD, '0);
		offer_beat(ACT_ADD, 32'sh8000_0001, 32'h0000_0003, '0);
		offer_beat(ACT_ADD, 32'shFFFF_FFFF, 32'h0000_0004, '0);
		drain_pool();
		// zero acts as one
		write_capacity(5'd0);
		offer_beat(ACT_ADD, 32'sh7FFF_FFFF, 32'h0000_0005, '0);
		drain_pool();
		// above the built depth acts as the depth: free slots again
		write_capacity(5'd31);
		offer_beat(ACT_ADD, 32'sh0000_8000, 32'h0000_0006, '0);
		offer_beat(ACT_SELECT, '0, '0, 32'h0000_0005);
		drain_pool();

		// Random phases: sender-light/receiver-heavy idling, then swapped, then none
		for (int ph = 0; ph < 10; ph++) begin
			write_capacity(phase_caps[ph]);
			send_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 86 : 0;
			recv_idle_pct = (ph < 3) ? 86 : (ph < 6) ? 24 : 0;
			// one long receiver hold-off while beats keep being offered
			if (ph == 6)
				hold_requests++;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				offer_random_beat();
				// short bursts with no gaps at all
				if ($urandom_range(15) == 0)
					for (int b = $urandom_range(8); b > 0; b--) begin
						send_idle_pct = 0;
						offer_random_beat();
					end
				send_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 86 : 0;
			end
			drain_pool();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

/* filelist.f */
sv/bep_pkg.sv
sv/bep_ifs.sv
sv/bep_ram.sv
sv/bep_mod.sv
sv/bep_ctrl.sv
sv/bounded_elite_pool.sv
sv/bep_chk.sv
test/elite_pool_checker.sv
test/testbench.sv
